/* rtl/tsbp_pkg.sv */
// Shared types and constants for the tape select block parser.
`timescale 1ns / 1ps
package tsbp_pkg;

  localparam int unsigned MaxOptionsDefault = 256;
  localparam int unsigned CountW = 9;
  localparam int unsigned OffsetW = 16;

  typedef enum logic [1:0] {
    ModeData   = 2'd0,
    ModeEos    = 2'd1,
    ModeQuery  = 2'd2,
    ModeIgnore = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    StConsumed = 2'd0,
    StDone     = 2'd1,
    StTrunc    = 2'd2,
    StQuery    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    PhLenLo   = 3'd0,
    PhLenHi   = 3'd1,
    PhCount   = 3'd2,
    PhOffLo   = 3'd3,
    PhOffHi   = 3'd4,
    PhTextLen = 3'd5,
    PhText    = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    ValZero  = 2'd0,
    ValOne   = 2'd1,
    ValTable = 2'd2
  } val_sel_e;

  // Parser status towards the output stage
  typedef struct packed {
    logic               done;
    logic [CountW-1:0]  count_next;
  } parse_status_t;

endpackage

/* rtl/tsbp_table.sv */
// Offset table: single-port-write, single-port-read synchronous memory.
`timescale 1ns / 1ps
module tsbp_table #(
  parameter int unsigned MAX_OPTIONS = tsbp_pkg::MaxOptionsDefault,
  localparam int unsigned AddrW = (MAX_OPTIONS > 1) ? $clog2(MAX_OPTIONS) : 1
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AddrW-1:0]             waddr_i,
  input  logic [tsbp_pkg::OffsetW-1:0] wdata_i,
  input  logic                         re_i,
  input  logic [AddrW-1:0]             raddr_i,
  output logic [tsbp_pkg::OffsetW-1:0] rdata_o
);
  import tsbp_pkg::*;

  logic [OffsetW-1:0] mem_q [MAX_OPTIONS];
  logic [OffsetW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold read data between reads so a stalled result keeps its value
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/tsbp_parser.sv */
// Byte-level parse state machine for the select block body.
`timescale 1ns / 1ps
module tsbp_parser #(
  parameter int unsigned MAX_OPTIONS = tsbp_pkg::MaxOptionsDefault,
  localparam int unsigned AddrW = (MAX_OPTIONS > 1) ? $clog2(MAX_OPTIONS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          byte_en_i,
  input  logic                          eos_en_i,
  input  logic [7:0]                    data_byte_i,
  output tsbp_pkg::parse_status_t       status_o,
  output logic [tsbp_pkg::CountW-1:0]   stored_count_o,
  output logic                          we_o,
  output logic [AddrW-1:0]              waddr_o,
  output logic [tsbp_pkg::OffsetW-1:0]  wdata_o
);
  import tsbp_pkg::*;

  localparam logic [CountW-1:0] MaxCnt = CountW'(MAX_OPTIONS);

  phase_e            phase_q, phase_d;
  logic [7:0]        options_left_q, options_left_d;
  logic [7:0]        text_left_q, text_left_d;
  logic [7:0]        offset_low_q, offset_low_d;
  logic [CountW-1:0] stored_count_q, stored_count_d;
  logic              done;
  logic              room;
  logic [7:0]        options_dec;
  logic [7:0]        text_dec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhLenLo;
      options_left_q <= '0;
      text_left_q    <= '0;
      offset_low_q   <= '0;
      stored_count_q <= '0;
    end else begin
      phase_q        <= phase_d;
      options_left_q <= options_left_d;
      text_left_q    <= text_left_d;
      offset_low_q   <= offset_low_d;
      stored_count_q <= stored_count_d;
    end
  end

  assign room        = (stored_count_q < MaxCnt);
  assign options_dec = options_left_q - 8'd1;
  assign text_dec    = text_left_q - 8'd1;

  always_comb begin
    phase_d        = phase_q;
    options_left_d = options_left_q;
    text_left_d    = text_left_q;
    offset_low_d   = offset_low_q;
    stored_count_d = stored_count_q;
    done           = 1'b0;
    we_o           = 1'b0;
    waddr_o        = stored_count_q[AddrW-1:0];
    wdata_o        = {data_byte_i, offset_low_q};

    if (eos_en_i) begin
      phase_d        = PhLenLo;
      options_left_d = '0;
      text_left_d    = '0;
    end else if (byte_en_i) begin
      unique case (phase_q)
        PhLenLo: phase_d = PhLenHi;
        PhLenHi: phase_d = PhCount;
        PhCount: begin
          stored_count_d = '0;
          options_left_d = data_byte_i;
          if (data_byte_i == 8'd0) begin
            phase_d = PhLenLo;
            done    = 1'b1;
          end else begin
            phase_d = PhOffLo;
          end
        end
        PhOffLo: begin
          offset_low_d = data_byte_i;
          phase_d      = PhOffHi;
        end
        PhOffHi: begin
          // Drop offsets once the table is full
          we_o    = room;
          phase_d = PhTextLen;
        end
        PhTextLen: begin
          if (room) begin
            stored_count_d = stored_count_q + CountW'(1);
          end
          text_left_d = data_byte_i;
          if (data_byte_i == 8'd0) begin
            options_left_d = options_dec;
            done           = (options_dec == 8'd0);
            phase_d        = done ? PhLenLo : PhOffLo;
          end else begin
            phase_d = PhText;
          end
        end
        PhText: begin
          text_left_d = text_dec;
          if (text_dec == 8'd0) begin
            options_left_d = options_dec;
            done           = (options_dec == 8'd0);
            phase_d        = done ? PhLenLo : PhOffLo;
          end
        end
        default: phase_d = PhLenLo;
      endcase
    end
  end

  assign status_o.done       = done;
  assign status_o.count_next = stored_count_d;
  assign stored_count_o      = stored_count_q;

endmodule

/* rtl/tape_select_block_parser.sv */
// Top level of the tape select block parser with its output register stage.
`timescale 1ns / 1ps
// Stream parser for the body of a tape-image select block.
// Input channel s_axis: tuser carries the item kind (data byte, end of
// stream, offset query); tdata carries the data byte and the query choice.
// Output channel m_axis: one result per input item; tuser carries the status
// (consumed, block complete, truncated, query answered), tdata the offset
// value and the number of offsets held in the table.
// The result is valid in the cycle after the input transfer; one item is taken
// every cycle unless the receiver stalls: the parser state advances in one step
// and the offset table, a synchronous memory, is read and written once per cycle.
// A query with an in-range choice reads the table at the transfer edge; the
// read data register is the result's offset field until the result is taken.
// While the receiver stalls, the result is held and s_axis_tready drops;
// it rises again in the cycle the held result is taken.
// Reset clears the parser to wait for the first length byte and empties the
// output stage; the table contents are undefined until written, and only
// committed entries are ever reported.
module tape_select_block_parser #(
  parameter int unsigned MAX_OPTIONS = tsbp_pkg::MaxOptionsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] data_byte, [15:8] choice
  input  logic [1:0]  s_axis_tuser,  // [1:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [15:0] offset_value, [24:16] options_stored
  output logic [1:0]  m_axis_tuser   // [1:0] status
);
  import tsbp_pkg::*;

  localparam int unsigned AddrW = (MAX_OPTIONS > 1) ? $clog2(MAX_OPTIONS) : 1;

  logic               in_xfer;
  mode_e              mode;
  logic [7:0]         data_byte;
  logic [7:0]         choice;
  logic               byte_en, eos_en, query_en;
  parse_status_t      pstat;
  logic [CountW-1:0]  stored_count;
  logic               we;
  logic [AddrW-1:0]   waddr;
  logic [OffsetW-1:0] wdata;
  logic [OffsetW-1:0] rdata;
  logic               in_range;

  logic               out_valid_q, out_valid_d;
  status_e            out_status_q, out_status_d;
  val_sel_e           out_sel_q, out_sel_d;
  logic [CountW-1:0]  out_count_q;
  logic [OffsetW-1:0] offset_value;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign mode          = mode_e'(s_axis_tuser);
  assign data_byte     = s_axis_tdata[7:0];
  assign choice        = s_axis_tdata[15:8];
  assign byte_en       = in_xfer && (mode == ModeData);
  assign eos_en        = in_xfer && (mode == ModeEos);
  assign query_en      = in_xfer && (mode == ModeQuery);
  assign in_range      = ({1'b0, choice} < stored_count);

  tsbp_parser #(
    .MAX_OPTIONS(MAX_OPTIONS)
  ) u_parser (
    .clk_i,
    .rst_ni,
    .byte_en_i      (byte_en),
    .eos_en_i       (eos_en),
    .data_byte_i    (data_byte),
    .status_o       (pstat),
    .stored_count_o (stored_count),
    .we_o           (we),
    .waddr_o        (waddr),
    .wdata_o        (wdata)
  );

  // An uncommitted entry is never in range, so a same-cycle write needs no bypass
  tsbp_table #(
    .MAX_OPTIONS(MAX_OPTIONS)
  ) u_table (
    .clk_i,
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (query_en && in_range),
    .raddr_i (choice[AddrW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_sel_d    = out_sel_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (in_xfer) begin
      out_valid_d = 1'b1;
      out_sel_d   = ValZero;
      unique case (mode)
        ModeData:   out_status_d = pstat.done ? StDone : StConsumed;
        ModeEos:    out_status_d = StTrunc;
        ModeQuery: begin
          out_status_d = StQuery;
          out_sel_d    = in_range ? ValTable : ValOne;
        end
        ModeIgnore: out_status_d = StConsumed;
        default:    out_status_d = StConsumed;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_sel_q    <= out_sel_d;
    if (in_xfer) begin
      out_count_q <= pstat.count_next;
    end
  end

  always_comb begin
    unique case (out_sel_q)
      ValTable: offset_value = rdata;
      ValOne:   offset_value = OffsetW'(1);
      ValZero:  offset_value = '0;
      default:  offset_value = '0;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {7'd0, out_count_q, offset_value};

endmodule

/* rtl/tsbp_checker.sv */
// Port-level assertions for the tape select block parser, bound to the top level.
`timescale 1ns / 1ps
module tsbp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import tsbp_pkg::*;

  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> m_axis_tvalid)
    else $error("result missing one cycle after input transfer");

  a_query_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (s_axis_tuser == ModeQuery) |=> (m_axis_tuser == StQuery))
    else $error("query not answered with query status");

  a_eos_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (s_axis_tuser == ModeEos) |=> (m_axis_tuser == StTrunc))
    else $error("end of stream not reported as truncation");

  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != StQuery) |-> (m_axis_tdata[15:0] == 16'd0))
    else $error("non-query result carries an offset");

endmodule

bind tape_select_block_parser tsbp_checker u_tsbp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
